FILE: rtl/bdu2e_pkg.sv
// Shared types, constants and the month table of the UTC-to-epoch converter.
package bdu2e_pkg;

    // Field widths of the input and output transfers.
    localparam int YEAR_W = 14;
    localparam int MON_W  = 9;
    localparam int DAY_W  = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int OUT_W  = 39;

    // Internal widths.
    localparam int TOD_W  = 17;   // seconds within the day, up to 115443
    localparam int POFF_W = 15;   // offset year before, always positive
    localparam int DAYS_W = 24;   // signed day count relative to 1970

    // Month folding: bias the month to be non-negative, divide by 12 by reciprocal.
    localparam logic [9:0]  MON_BIAS    = 10'd264;   // 22 * 12
    localparam logic [19:0] RECIP12     = 20'd683;   // 683 / 2^13 ~ 1/12
    localparam logic [15:0] YEAR_BIAS   = 16'd8277;  // 1900 - 22 - 1 + 6400

    // Division of the year quarter by 25 by reciprocal.
    localparam logic [25:0] RECIP25     = 26'd5243;  // 5243 / 2^17 ~ 1/25

    // Days from the biased year count to 1970, less one for a day of month from 1.
    localparam logic signed [24:0] DAY_BIAS = -25'sd3056715;
    localparam logic signed [24:0] DAYS_PER_YEAR = 25'sd365;
    localparam logic signed [41:0] SEC_PER_DAY   = 42'sd86400;

    // Payload after the month fold.
    typedef struct packed {
        logic [POFF_W-1:0] p_off;
        logic [3:0]        mon;
        logic [DAY_W-1:0]  day;
        logic [TOD_W-1:0]  tod;
    } t_fold;

    // Payload after the day count.
    typedef struct packed {
        logic signed [DAYS_W-1:0] days;
        logic [TOD_W-1:0]         tod;
    } t_days;

    // Days before the first of the month; leap selects the leap-year column.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
        logic [8:0] d;
        unique case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (mon >= 4'd2)) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

FILE: rtl/bdu2e_month_fold.sv
// Two pipeline stages that fold the month into 0..11 and form the offset year.
module bdu2e_month_fold (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bdu2e_pkg::YEAR_W-1:0]   i_year,
    input  logic [bdu2e_pkg::MON_W-1:0]    i_mon,
    input  logic [bdu2e_pkg::DAY_W-1:0]    i_day,
    input  logic [bdu2e_pkg::HOUR_W-1:0]   i_hour,
    input  logic [bdu2e_pkg::MIN_W-1:0]    i_min,
    input  logic [bdu2e_pkg::SEC_W-1:0]    i_sec,
    output logic                           o_valid,
    input  logic                           i_stall,
    output bdu2e_pkg::t_fold               o_data
);

    logic                          r_v_a;
    logic                          r_v_b;
    logic                          w_rdy_a;
    logic                          w_rdy_b;

    logic [9:0]                    n_x;
    logic [19:0]                   w_prod;
    logic [5:0]                    n_q;
    logic [bdu2e_pkg::TOD_W-1:0]   n_tod;
    logic [9:0]                    r_x;
    logic [5:0]                    r_q;
    logic [bdu2e_pkg::YEAR_W-1:0]  r_year;
    logic [bdu2e_pkg::DAY_W-1:0]   r_day;
    logic [bdu2e_pkg::TOD_W-1:0]   r_tod;

    logic [9:0]                    w_rem;
    logic [15:0]                   w_poff;
    bdu2e_pkg::t_fold              n_fold;
    bdu2e_pkg::t_fold              r_fold;

    // Each stage loads when it is empty or the stage after it moves on.
    assign w_rdy_b = !r_v_b || !i_stall;
    assign w_rdy_a = !r_v_a || w_rdy_b;
    assign o_stall = !w_rdy_a;

    // Stage A: biased month times the reciprocal of 12, and time of day.
    always_comb begin
        n_x    = {i_mon[bdu2e_pkg::MON_W-1], i_mon} + bdu2e_pkg::MON_BIAS;
        w_prod = {10'd0, n_x} * bdu2e_pkg::RECIP12;
        n_q    = w_prod[18:13];
        n_tod  = bdu2e_pkg::TOD_W'({12'd0, i_hour} * 17'd3600)
               + bdu2e_pkg::TOD_W'({11'd0, i_min} * 17'd60)
               + {11'd0, i_sec};
    end

    // Stage B: remainder gives the month, quotient carries into the year.
    always_comb begin
        w_rem        = r_x - {1'b0, r_q, 3'b000} - {2'b00, r_q, 2'b00};
        w_poff       = {{2{r_year[bdu2e_pkg::YEAR_W-1]}}, r_year} + {10'd0, r_q}
                     + bdu2e_pkg::YEAR_BIAS;
        n_fold.p_off = w_poff[bdu2e_pkg::POFF_W-1:0];
        n_fold.mon   = w_rem[3:0];
        n_fold.day   = r_day;
        n_fold.tod   = r_tod;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_v_a <= i_valid;
            end
            if (w_rdy_b) begin
                r_v_b <= r_v_a;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_x    <= n_x;
            r_q    <= n_q;
            r_year <= i_year;
            r_day  <= i_day;
            r_tod  <= n_tod;
        end
        if (w_rdy_b && r_v_a) begin
            r_fold <= n_fold;
        end
    end

    assign o_valid = r_v_b;
    assign o_data  = r_fold;

endmodule

FILE: rtl/bdu2e_day_count.sv
// Two pipeline stages that count days since 1970 with the Gregorian leap rule.
module bdu2e_day_count (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  bdu2e_pkg::t_fold   i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output bdu2e_pkg::t_days   o_data
);

    logic                              r_v_c;
    logic                              r_v_d;
    logic                              w_rdy_c;
    logic                              w_rdy_d;

    logic [25:0]                       w_prod;
    logic [12:0]                       r_q4;
    logic [7:0]                        r_q25;
    logic [bdu2e_pkg::POFF_W-1:0]      r_poff;
    logic [3:0]                        r_mon;
    logic [bdu2e_pkg::DAY_W-1:0]       r_day;
    logic [bdu2e_pkg::TOD_W-1:0]       r_tod;

    logic [12:0]                       w_r25;
    logic                              w_leap;
    logic [8:0]                        w_mstart;
    logic signed [24:0]                w_sum;
    bdu2e_pkg::t_days                  n_days;
    bdu2e_pkg::t_days                  r_days;

    assign w_rdy_d = !r_v_d || !i_stall;
    assign w_rdy_c = !r_v_c || w_rdy_d;
    assign o_stall = !w_rdy_c;

    // Stage C: the quarter of the offset year divided by 25 gives the century count.
    assign w_prod = {13'd0, i_data.p_off[bdu2e_pkg::POFF_W-1:2]} * bdu2e_pkg::RECIP25;

    // Stage D: leap test from the remainders, then the day count.
    // The year is leap when the year before ends in 3 mod 4, unless it starts a
    // century that is not a multiple of 400.
    always_comb begin
        w_r25    = r_q4 - 13'({5'd0, r_q25} * 13'd25);
        w_leap   = (r_poff[1:0] == 2'b11)
                && ((w_r25[4:0] != 5'd24) || (r_q25[1:0] == 2'b11));
        w_mstart = bdu2e_pkg::month_start(w_leap, r_mon);
        w_sum    = $signed({10'd0, r_poff}) * bdu2e_pkg::DAYS_PER_YEAR
                 + $signed({12'd0, r_q4})
                 - $signed({17'd0, r_q25})
                 + $signed({19'd0, r_q25[7:2]})
                 + $signed({16'd0, w_mstart})
                 + $signed({20'd0, r_day})
                 + bdu2e_pkg::DAY_BIAS;
        n_days.days = w_sum[bdu2e_pkg::DAYS_W-1:0];
        n_days.tod  = r_tod;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
        end else begin
            if (w_rdy_c) begin
                r_v_c <= i_valid;
            end
            if (w_rdy_d) begin
                r_v_d <= r_v_c;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy_c && i_valid) begin
            r_q4   <= i_data.p_off[bdu2e_pkg::POFF_W-1:2];
            r_q25  <= w_prod[24:17];
            r_poff <= i_data.p_off;
            r_mon  <= i_data.mon;
            r_day  <= i_data.day;
            r_tod  <= i_data.tod;
        end
        if (w_rdy_d && r_v_c) begin
            r_days <= n_days;
        end
    end

    assign o_valid = r_v_d;
    assign o_data  = r_days;

endmodule

FILE: rtl/bdu2e_sec_scale.sv
// Two pipeline stages that scale days to seconds and add the time of day.
module bdu2e_sec_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  bdu2e_pkg::t_days              i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bdu2e_pkg::OUT_W-1:0]   o_secs
);

    logic                              r_v_e;
    logic                              r_v_f;
    logic                              w_rdy_e;
    logic                              w_rdy_f;

    logic signed [41:0]                w_prod;
    logic [bdu2e_pkg::OUT_W-1:0]       r_prod;
    logic [bdu2e_pkg::TOD_W-1:0]       r_tod;
    logic [bdu2e_pkg::OUT_W-1:0]       r_secs;

    assign w_rdy_f = !r_v_f || !i_stall;
    assign w_rdy_e = !r_v_e || w_rdy_f;
    assign o_stall = !w_rdy_e;

    // Stage E: days times 86400; only the low result bits are kept.
    assign w_prod = {{18{i_data.days[bdu2e_pkg::DAYS_W-1]}}, i_data.days}
                  * bdu2e_pkg::SEC_PER_DAY;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_e <= 1'b0;
            r_v_f <= 1'b0;
        end else begin
            if (w_rdy_e) begin
                r_v_e <= i_valid;
            end
            if (w_rdy_f) begin
                r_v_f <= r_v_e;
            end
        end
    end

    // Payload registers; stage F adds the seconds of the day.
    always_ff @(posedge i_clk) begin
        if (w_rdy_e && i_valid) begin
            r_prod <= w_prod[bdu2e_pkg::OUT_W-1:0];
            r_tod  <= i_data.tod;
        end
        if (w_rdy_f && r_v_e) begin
            r_secs <= r_prod + {{(bdu2e_pkg::OUT_W-bdu2e_pkg::TOD_W){1'b0}}, r_tod};
        end
    end

    assign o_valid = r_v_f;
    assign o_secs  = r_secs;

endmodule

FILE: rtl/broken_down_utc_to_epoch_seconds_core.sv
// An input transfer is registered through stages A to F in order, and its result
// is held in the stage F output register until the output transfer.
// Throughput: one transfer per cycle unless stalled; six register stages, each
// moving on when empty or when the stage after it moves, so bubbles fill under stall.
// Reset (synchronous, active low) clears every stage valid bit; payloads are not reset.
// Top level of the broken-down UTC time to epoch seconds converter.
module broken_down_utc_to_epoch_seconds_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [bdu2e_pkg::YEAR_W-1:0]         i_years_since_1900,
    input  logic [bdu2e_pkg::MON_W-1:0]          i_month_index,
    input  logic [bdu2e_pkg::DAY_W-1:0]          i_day_of_month,
    input  logic [bdu2e_pkg::HOUR_W-1:0]         i_hour_of_day,
    input  logic [bdu2e_pkg::MIN_W-1:0]          i_minute_of_hour,
    input  logic [bdu2e_pkg::SEC_W-1:0]          i_second_of_minute,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [bdu2e_pkg::OUT_W-1:0]   o_epoch_seconds
);

    logic                          w_fold_valid;
    logic                          w_fold_stall;
    bdu2e_pkg::t_fold              w_fold;
    logic                          w_days_valid;
    logic                          w_days_stall;
    bdu2e_pkg::t_days              w_days;
    logic [bdu2e_pkg::OUT_W-1:0]   w_secs;

    // Month fold and offset year.
    bdu2e_month_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_year  (i_years_since_1900),
        .i_mon   (i_month_index),
        .i_day   (i_day_of_month),
        .i_hour  (i_hour_of_day),
        .i_min   (i_minute_of_hour),
        .i_sec   (i_second_of_minute),
        .o_valid (w_fold_valid),
        .i_stall (w_fold_stall),
        .o_data  (w_fold)
    );

    // Day count relative to 1970.
    bdu2e_day_count u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fold_valid),
        .o_stall (w_fold_stall),
        .i_data  (w_fold),
        .o_valid (w_days_valid),
        .i_stall (w_days_stall),
        .o_data  (w_days)
    );

    // Scaling to seconds.
    bdu2e_sec_scale u_secs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_days_valid),
        .o_stall (w_days_stall),
        .i_data  (w_days),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_secs  (w_secs)
    );

    assign o_epoch_seconds = $signed(w_secs);

endmodule
